// ===== design/wpcs_pkg.sv =====
// ----------------------------------------------------------------------------
// wpcs_pkg: shared definitions for the wheel period capture speed block
// Field widths, reset constants and the sequencer state encoding.
// ----------------------------------------------------------------------------
package wpcs_pkg;

  localparam int DATA_W = 16;
  localparam int DEPTH_DEFAULT = 10;
  localparam logic [DATA_W-1:0] SCALE_RESET = 16'd10445;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_FIND,
    ST_SUM,
    ST_DIV1_LOAD,
    ST_DIV,
    ST_DIV2_LOAD,
    ST_FINISH
  } state_t;

endpackage

// ===== design/wheel_period_capture_speed.sv =====
// ----------------------------------------------------------------------------
// wheel_period_capture_speed: encoder capture period and speed estimate
// Pairs timer captures into periods, keeps a ring of periods and reports a
// trimmed, position-weighted average turned into a speed for every word.
// ----------------------------------------------------------------------------
// Each input word is either a capture stamp (s_tuser = 0) or a command that
// clears the period history (s_tuser = 1). Every accepted word yields exactly
// one output word carrying the completion flag, the latest period and a speed
// equal to distance_scale divided by the trimmed weighted average period.
// The block handles one word at a time: s_tready is high only while the
// sequencer is idle. Each word takes two passes over the ring, one entry per
// cycle (first the max/min search, then the weighted sum through a single
// multiply-accumulate), followed by two passes through one shared restoring
// divider that retires one quotient bit per cycle: first the average, then
// the speed. A finished result sits in the output register, so the next word
// is accepted while the previous result still waits downstream.
module wheel_period_capture_speed #(
  parameter int DEPTH = wpcs_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: distance_scale write.
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] capture_value
  input  logic [0:0]  s_tuser,   // [0] kind: 0 capture, 1 clear history
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] period, [31:16] speed
  output logic [0:0]  m_tuser    // [0] period_done
);

  localparam int DW    = wpcs_pkg::DATA_W;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WSUM  = DEPTH * (DEPTH + 1) / 2;
  localparam int WT_W  = $clog2(WSUM + 1);
  localparam int ACC_W = DW + WT_W;
  localparam int CNT_W = $clog2(ACC_W);

  // Architectural state.
  logic [DW-1:0]    ring [DEPTH];
  logic [IDX_W-1:0] write_slot;
  logic             awaiting_second;
  logic [DW-1:0]    first_stamp;
  logic [DW-1:0]    last_period;
  logic [DW-1:0]    distance_scale;

  // Per-word working registers.
  wpcs_pkg::state_t state, state_next;
  logic             done_flag;
  logic [IDX_W-1:0] ptr, idx, hi_pos, lo_pos;
  logic [DW-1:0]    hi_val, lo_val;
  logic [ACC_W-1:0] acc;
  logic [WT_W-1:0]  weight;
  logic [ACC_W-1:0] quo;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             div_sel;
  logic [DW-1:0]    speed;

  // Datapath helpers.
  logic [DW-1:0]    cur;
  logic             last_idx;
  logic [IDX_W-1:0] ptr_inc;
  logic [WT_W-1:0]  wterm;
  logic [ACC_W-1:0] prod;
  logic [DW:0]      rem_sh, rem_sub;
  logic             fits;
  logic [DW-1:0]    rem_next;
  logic [ACC_W-1:0] quo_next;
  logic             div_last;
  logic [DW-1:0]    new_period;
  logic             in_accept, out_free;

  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Wrapped difference: 0xFFFF - first + second equals second + ~first
  // modulo 2^16, and covers the second > first case as well only when
  // adjusted, so both branches are kept explicit.
  always_comb begin
    if (s_tdata > first_stamp) begin
      new_period = s_tdata - first_stamp;
    end else begin
      new_period = s_tdata + ~first_stamp;
    end
  end

  assign cur      = ring[ptr];
  assign last_idx = (idx == IDX_W'(DEPTH - 1));
  assign ptr_inc  = (ptr == IDX_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  assign wterm    = WT_W'(idx) + 1'b1;
  assign prod     = ACC_W'(cur) * ACC_W'(wterm);

  // Shared restoring divider step: one quotient bit per cycle.
  assign rem_sh   = {rem, quo[ACC_W-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs};
  assign fits     = (rem_sh >= {1'b0, dvs});
  assign rem_next = fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
  assign quo_next = {quo[ACC_W-2:0], fits};
  assign div_last = (cnt == CNT_W'(ACC_W - 1));

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wpcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      wpcs_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = wpcs_pkg::ST_START;
      end
      wpcs_pkg::ST_START: state_next = wpcs_pkg::ST_FIND;
      wpcs_pkg::ST_FIND: begin
        if (last_idx) state_next = wpcs_pkg::ST_SUM;
      end
      wpcs_pkg::ST_SUM: begin
        if (last_idx) state_next = wpcs_pkg::ST_DIV1_LOAD;
      end
      wpcs_pkg::ST_DIV1_LOAD: begin
        state_next = (weight == '0) ? wpcs_pkg::ST_FINISH : wpcs_pkg::ST_DIV;
      end
      wpcs_pkg::ST_DIV: begin
        if (div_last) begin
          state_next = div_sel ? wpcs_pkg::ST_FINISH : wpcs_pkg::ST_DIV2_LOAD;
        end
      end
      wpcs_pkg::ST_DIV2_LOAD: begin
        state_next = (quo[DW-1:0] == '0) ? wpcs_pkg::ST_FINISH : wpcs_pkg::ST_DIV;
      end
      wpcs_pkg::ST_FINISH: begin
        if (out_free) state_next = wpcs_pkg::ST_IDLE;
      end
      default: state_next = wpcs_pkg::ST_IDLE;
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_scale <= wpcs_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      distance_scale <= cfg_wdata;
    end
  end

  // Capture pairing and period ring, updated when a word is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) ring[i] <= '0;
      write_slot      <= '0;
      awaiting_second <= 1'b0;
      first_stamp     <= '0;
      last_period     <= '0;
      done_flag       <= 1'b0;
    end else if (in_accept) begin
      done_flag <= 1'b0;
      if (s_tuser[0]) begin
        for (int i = 0; i < DEPTH; i++) ring[i] <= '0;
      end else if (!awaiting_second) begin
        first_stamp     <= s_tdata;
        awaiting_second <= 1'b1;
      end else begin
        last_period       <= new_period;
        ring[write_slot]  <= new_period;
        write_slot        <= (write_slot == IDX_W'(DEPTH - 1)) ? '0 : write_slot + 1'b1;
        awaiting_second   <= 1'b0;
        done_flag         <= 1'b1;
      end
    end
  end

  // Sequenced speed computation.
  always_ff @(posedge clk) begin
    case (state)
      wpcs_pkg::ST_START: begin
        ptr <= write_slot;
        idx <= '0;
      end
      wpcs_pkg::ST_FIND: begin
        // Oldest entry first; only a strictly larger or smaller value moves
        // the position, so the first occurrence wins.
        if (idx == '0) begin
          hi_val <= cur;
          lo_val <= cur;
          hi_pos <= '0;
          lo_pos <= '0;
        end else begin
          if (cur > hi_val) begin
            hi_val <= cur;
            hi_pos <= idx;
          end
          if (cur < lo_val) begin
            lo_val <= cur;
            lo_pos <= idx;
          end
        end
        ptr <= ptr_inc;
        idx <= last_idx ? '0 : idx + 1'b1;
        acc    <= '0;
        weight <= '0;
      end
      wpcs_pkg::ST_SUM: begin
        if (idx != hi_pos && idx != lo_pos) begin
          acc    <= acc + prod;
          weight <= weight + wterm;
        end
        ptr <= ptr_inc;
        idx <= last_idx ? '0 : idx + 1'b1;
      end
      wpcs_pkg::ST_DIV1_LOAD: begin
        quo     <= acc;
        rem     <= '0;
        dvs     <= DW'(weight);
        cnt     <= '0;
        div_sel <= 1'b0;
        speed   <= '0;
      end
      wpcs_pkg::ST_DIV: begin
        quo <= quo_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (div_last && div_sel) speed <= quo_next[DW-1:0];
      end
      wpcs_pkg::ST_DIV2_LOAD: begin
        // The weighted average never exceeds the largest entry, so the
        // low bits of the first quotient hold it completely.
        quo     <= ACC_W'(distance_scale);
        rem     <= '0;
        dvs     <= quo[DW-1:0];
        cnt     <= '0;
        div_sel <= 1'b1;
        speed   <= '0;
      end
      default: ;
    endcase
  end

  // Output register: holds a result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == wpcs_pkg::ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == wpcs_pkg::ST_FINISH && out_free) begin
      m_tdata <= {speed, last_period};
      m_tuser <= done_flag;
    end
  end

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    write_slot <= IDX_W'(DEPTH - 1))
    else $error("write slot left the ring");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    state == wpcs_pkg::ST_DIV |-> rem < dvs)
    else $error("divider remainder not below divisor");

  a_pair_closes: assert property (@(posedge clk) disable iff (rst)
    in_accept && !s_tuser[0] && awaiting_second |=> !awaiting_second && done_flag)
    else $error("second capture did not close the pair");

  a_extremes_order: assert property (@(posedge clk) disable iff (rst)
    state == wpcs_pkg::ST_FIND && idx != '0 |-> hi_val >= lo_val)
    else $error("running maximum below running minimum");
`endif

endmodule
